@@ rtl/easf_pkg.sv @@
`default_nettype none

package easf_pkg;

    // Encoder count and fraction widths; one turn is 2^(COUNT_BITS+FRAC_BITS) units
    localparam int COUNT_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // Register map, word index on the configuration port
    typedef enum logic [2:0] {
        REG_JUMP_THRESHOLD  = 3'd0,
        REG_SPIKE_CONFIRM   = 3'd1,
        REG_FILTER_ALPHA    = 3'd2,
        REG_ANGLE_OFFSET    = 3'd3,
        REG_DIRECTION       = 3'd4
    } reg_index_t;

    // Register reset values
    localparam logic [11:0] JUMP_THRESHOLD_RST = 12'd2048;
    localparam logic [7:0]  SPIKE_CONFIRM_RST  = 8'd1;
    localparam logic [16:0] FILTER_ALPHA_RST   = 17'd65536;
    localparam logic [27:0] ANGLE_OFFSET_RST   = 28'd0;

    // Q16 gain: unity and the rounding half
    localparam int unsigned ALPHA_Q    = 16;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [16:0] ALPHA_HALF = 17'd32768;

    // Spike run counter saturates here
    localparam logic [7:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic [11:0] jump_threshold;
        logic [7:0]  spike_confirm_count;
        logic [16:0] filter_alpha;
        logic [27:0] angle_offset;
        logic        reverse_direction;
    } cfg_t;

    typedef struct packed {
        logic       accept;     // sample passes the spike test
        logic [7:0] spike_run;  // next value of the spike run counter
    } step_ctl_t;

endpackage

`default_nettype wire

@@ rtl/easf_step.sv @@
`default_nettype none

module easf_step
    import easf_pkg::*;
(
    input  wire cfg_t                                  cfg,
    input  wire logic                                  seeded,
    input  wire logic [COUNT_BITS-1:0]                 prev_raw,
    input  wire logic [COUNT_BITS+FRAC_BITS-1:0]       filter_angle,
    input  wire logic [7:0]                            spike_run,
    input  wire logic [7:0]                            high_byte,
    input  wire logic [7:0]                            low_byte,
    output step_ctl_t                                  ctl,
    output logic [COUNT_BITS-1:0]                      raw,
    output logic [COUNT_BITS+FRAC_BITS-1:0]            filter_next,
    output logic [11:0]                                raw_count,
    output logic [27:0]                                angle_out
);

    localparam int TURN_BITS = COUNT_BITS + FRAC_BITS;
    localparam int MW        = ((COUNT_BITS > 12) ? COUNT_BITS : 12) + 1;
    localparam int RW        = (COUNT_BITS > 12) ? COUNT_BITS : 12;
    localparam int XW        = (TURN_BITS > 28) ? TURN_BITS : 28;
    localparam int PW        = TURN_BITS + 18;
    localparam logic [7:0] HI_MASK = 8'((17'd1 << (COUNT_BITS - 8)) - 17'd1);

    logic [15:0]                  raw16;
    logic [TURN_BITS-1:0]         raw_units;
    logic [COUNT_BITS-1:0]        prev_eff;
    logic [TURN_BITS-1:0]         filt_eff;
    logic [7:0]                   run_eff;
    logic [COUNT_BITS-1:0]        d;
    logic [COUNT_BITS-1:0]        mag;
    logic                         big;
    logic [7:0]                   run_inc;
    logic                         reject;
    logic [16:0]                  alpha_sat;
    logic signed [17:0]           alpha_s;
    logic signed [TURN_BITS-1:0]  diff;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         rounded;
    logic [XW-1:0]                off_x;
    logic [TURN_BITS-1:0]         v0;
    logic [TURN_BITS-1:0]         v;
    logic signed [XW-1:0]         angle_x;
    logic [RW-1:0]                raw_x;

    // Raw count from the two bytes
    assign raw16     = {high_byte & HI_MASK, low_byte};
    assign raw       = raw16[COUNT_BITS-1:0];
    assign raw_units = {raw, {FRAC_BITS{1'b0}}};

    // First sample seeds the state
    assign prev_eff = seeded ? prev_raw : raw;
    assign filt_eff = seeded ? filter_angle : raw_units;
    assign run_eff  = seeded ? spike_run : 8'd0;

    // Jump test, modulo one turn
    assign d   = raw - prev_eff;
    assign mag = d[COUNT_BITS-1] ? (COUNT_BITS'(0) - d) : d;
    assign big = MW'(mag) > MW'(cfg.jump_threshold);

    assign run_inc = (run_eff == RUN_MAX) ? RUN_MAX : run_eff + 8'd1;
    assign reject  = big && (run_inc < cfg.spike_confirm_count);

    assign ctl.accept    = !reject;
    assign ctl.spike_run = reject ? run_inc : 8'd0;

    // Filter step: floor((alpha * diff + half) / 2^16)
    assign alpha_sat = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
    assign alpha_s   = $signed({1'b0, alpha_sat});
    assign diff      = $signed(raw_units - filt_eff);
    assign prod      = PW'(alpha_s) * PW'(diff);
    assign rounded   = prod + PW'($signed({1'b0, ALPHA_HALF}));

    assign filter_next = filt_eff + rounded[TURN_BITS+ALPHA_Q-1:ALPHA_Q];

    // Offset, direction and wrap to a signed half turn
    assign off_x = XW'(cfg.angle_offset);
    assign v0    = filter_next - off_x[TURN_BITS-1:0];
    assign v     = cfg.reverse_direction ? (TURN_BITS'(0) - v0) : v0;

    assign angle_x   = XW'($signed(v));
    assign angle_out = angle_x[27:0];
    assign raw_x     = RW'(raw);
    assign raw_count = raw_x[11:0];

endmodule

`default_nettype wire

@@ rtl/encoder_angle_spike_filter.sv @@
`default_nettype none

// A request is registered in the input stage and moves on into the result register, which
// drives m_tvalid, once that register is free or being drained.
// Throughput: one request per cycle while the result side does not stall; the filter
// feedback is combinational (an 18x28 multiply and the wrap adds from input stage to state).
// Rejected spikes give no result and pass the input stage like any other request.
// Reset: aresetn synchronous, active low; clears valids, seed flag, spike counter, registers.
module encoder_angle_spike_filter
    import easf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // high_byte [7:0], low_byte [15:8]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // raw_count [11:0], angle_out [39:12]

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TURN_BITS = COUNT_BITS + FRAC_BITS;

    cfg_t                    cfg_reg;
    reg_index_t              reg_idx;
    logic                    cfg_wr;

    logic                    in_valid_reg;
    logic [7:0]              high_byte_reg;
    logic [7:0]              low_byte_reg;
    logic                    advance;

    logic                    seeded_reg;
    logic [COUNT_BITS-1:0]   prev_raw_reg;
    logic [TURN_BITS-1:0]    filter_angle_reg;
    logic [7:0]              spike_run_reg;

    step_ctl_t               ctl;
    logic [COUNT_BITS-1:0]   raw;
    logic [TURN_BITS-1:0]    filter_next;
    logic [11:0]             raw_count;
    logic [27:0]             angle_out;

    logic                    out_valid_reg;
    logic [11:0]             raw_count_reg;
    logic [27:0]             angle_out_reg;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.jump_threshold      <= JUMP_THRESHOLD_RST;
            cfg_reg.spike_confirm_count <= SPIKE_CONFIRM_RST;
            cfg_reg.filter_alpha        <= FILTER_ALPHA_RST;
            cfg_reg.angle_offset        <= ANGLE_OFFSET_RST;
            cfg_reg.reverse_direction   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_JUMP_THRESHOLD: cfg_reg.jump_threshold      <= pwdata[11:0];
                REG_SPIKE_CONFIRM:  cfg_reg.spike_confirm_count <= pwdata[7:0];
                REG_FILTER_ALPHA:   cfg_reg.filter_alpha        <= pwdata[16:0];
                REG_ANGLE_OFFSET:   cfg_reg.angle_offset        <= pwdata[27:0];
                REG_DIRECTION:      cfg_reg.reverse_direction   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (reg_idx)
            REG_JUMP_THRESHOLD: prdata = 32'(cfg_reg.jump_threshold);
            REG_SPIKE_CONFIRM:  prdata = 32'(cfg_reg.spike_confirm_count);
            REG_FILTER_ALPHA:   prdata = 32'(cfg_reg.filter_alpha);
            REG_ANGLE_OFFSET:   prdata = 32'(cfg_reg.angle_offset);
            REG_DIRECTION:      prdata = 32'(cfg_reg.reverse_direction);
            default:            prdata = 32'd0;
        endcase
    end

    // Input stage: moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            high_byte_reg <= s_tdata[7:0];
            low_byte_reg  <= s_tdata[15:8];
        end
    end

    easf_step u_step (
        .cfg          (cfg_reg),
        .seeded       (seeded_reg),
        .prev_raw     (prev_raw_reg),
        .filter_angle (filter_angle_reg),
        .spike_run    (spike_run_reg),
        .high_byte    (high_byte_reg),
        .low_byte     (low_byte_reg),
        .ctl          (ctl),
        .raw          (raw),
        .filter_next  (filter_next),
        .raw_count    (raw_count),
        .angle_out    (angle_out)
    );

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg       <= 1'b0;
            spike_run_reg    <= 8'd0;
            prev_raw_reg     <= '0;
            filter_angle_reg <= '0;
        end else if (advance) begin
            seeded_reg    <= 1'b1;
            spike_run_reg <= ctl.spike_run;
            if (ctl.accept) begin
                prev_raw_reg     <= raw;
                filter_angle_reg <= filter_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ctl.accept;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ctl.accept) begin
            raw_count_reg <= raw_count;
            angle_out_reg <= angle_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {angle_out_reg, raw_count_reg};

`ifndef SYNTHESIS
    // Any processed request leaves the block seeded
    a_seeded_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> seeded_reg)
        else $error("seed flag not set after a processed request");

    // A rejected spike always leaves a non-zero run count
    a_reject_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !ctl.accept |=> spike_run_reg != 8'd0)
        else $error("spike rejected without counting");

    // An accepted sample clears the run count
    a_accept_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl.accept |=> spike_run_reg == 8'd0)
        else $error("spike run not cleared on accepted sample");

    // A new result only appears after the input stage moved
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result appeared without a processed request");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import easf_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 8;

    typedef struct {
        logic [11:0] raw_count;
        logic [27:0] angle_out;
    } angle_result_t;

    // Scoreboard: own copy of the filter state and settings, expected results in order
    class angle_tracker;
        logic [11:0]   jump_threshold = JUMP_THRESHOLD_RST;
        logic [7:0]    spike_confirm  = SPIKE_CONFIRM_RST;
        logic [16:0]   filter_alpha   = FILTER_ALPHA_RST;
        logic [27:0]   angle_offset   = ANGLE_OFFSET_RST;
        logic          flip_angle     = 1'b0;
        logic          seeded         = 1'b0;
        logic [11:0]   prev_raw       = '0;
        logic [27:0]   filter_angle   = '0;
        logic [7:0]    spike_run      = '0;
        angle_result_t pending_angles[$];
        int            errors         = 0;
        int            requests       = 0;
        int            checked        = 0;
        int            rejected       = 0;

        // returns what the register holds after the write
        function logic [31:0] set_reg(reg_index_t idx, logic [31:0] val);
            case (idx)
                REG_JUMP_THRESHOLD: begin
                    jump_threshold = val[11:0];
                    return {20'h0, jump_threshold};
                end
                REG_SPIKE_CONFIRM: begin
                    spike_confirm = val[7:0];
                    return {24'h0, spike_confirm};
                end
                REG_FILTER_ALPHA: begin
                    filter_alpha = val[16:0];
                    return {15'h0, filter_alpha};
                end
                REG_ANGLE_OFFSET: begin
                    angle_offset = val[27:0];
                    return {4'h0, angle_offset};
                end
                default: begin
                    flip_angle = val[0];
                    return {31'h0, flip_angle};
                end
            endcase
        endfunction

        function void take_sample(logic [7:0] hi, logic [7:0] lo);
            logic [11:0]   raw;
            logic [27:0]   raw_units;
            logic [11:0]   dcount;
            int            mag;
            logic [16:0]   gain;
            logic [27:0]   diff;
            longint        prod;
            longint        step;
            logic [27:0]   v;
            angle_result_t r;
            requests++;
            raw       = {hi[3:0], lo};
            raw_units = {raw, 16'h0};
            // first sample seeds the filter, so its jump is zero
            if (!seeded) begin
                prev_raw     = raw;
                filter_angle = raw_units;
                spike_run    = '0;
                seeded       = 1'b1;
            end
            // jump test modulo one turn
            dcount = raw - prev_raw;
            mag    = dcount[11] ? (4096 - int'(dcount)) : int'(dcount);
            if (mag > int'(jump_threshold)) begin
                if (spike_run < RUN_MAX)
                    spike_run++;
                if (spike_run < spike_confirm) begin
                    rejected++;
                    return;
                end
                spike_run = '0;
            end else begin
                spike_run = '0;
            end
            prev_raw = raw;
            // wrap-aware low-pass step, round half up, gain saturated at unity
            gain = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
            diff = raw_units - filter_angle;
            prod = longint'(gain) * longint'($signed(diff)) + longint'(ALPHA_HALF);
            step = prod >>> ALPHA_Q;
            filter_angle = filter_angle + step[27:0];
            // offset, direction, signed half-turn view
            v = filter_angle - angle_offset;
            if (flip_angle)
                v = 28'd0 - v;
            r.raw_count = raw;
            r.angle_out = v;
            pending_angles.push_back(r);
        endfunction

        function void check_angle(logic [39:0] data);
            angle_result_t e;
            if (pending_angles.size() == 0) begin
                $error("unexpected result: raw_count %0d angle_out %0d",
                       data[11:0], $signed(data[39:12]));
                errors++;
                return;
            end
            e = pending_angles.pop_front();
            checked++;
            if (data[11:0] !== e.raw_count) begin
                $error("raw_count: expected %0d, got %0d", e.raw_count, data[11:0]);
                errors++;
            end
            if (data[39:12] !== e.angle_out) begin
                $error("angle_out: expected %0d, got %0d",
                       $signed(e.angle_out), $signed(data[39:12]));
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // high_byte [7:0], low_byte [15:8]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // raw_count [11:0], angle_out [39:12]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    angle_tracker sb = new();

    int src_idle_pct = 24;
    int snk_idle_pct = 24;
    bit hold_req     = 1'b0;
    int settings     = 1;
    int sent_total   = 0;

    encoder_angle_spike_filter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Monitor both handshakes on the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.take_sample(s_tdata[7:0], s_tdata[15:8]);
            if (m_tvalid && m_tready)
                sb.check_angle(m_tdata);
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Overall time limit
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One request; may idle first, returns on the accepting edge
    task automatic send_bytes(logic [7:0] hi, logic [7:0] lo);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata  <= {lo, hi};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_total++;
    endtask

    // Raw count with random unused high-byte bits
    task automatic send_count(logic [11:0] cnt);
        logic [3:0] junk;
        junk = 4'($urandom_range(15));
        send_bytes({junk, cnt[11:8]}, cnt[7:0]);
    endtask

    // Let every expected result arrive, then let rejected requests drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_angles.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write a register, then read it back
    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        logic [31:0] stored;
        stored = sb.set_reg(idx, val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== stored) begin
            $error("%s readback: expected %0d, got %0d", idx.name(), stored, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(logic [11:0] thr, logic [7:0] confirm, logic [16:0] gain,
                             logic [27:0] offset, logic rev);
        write_reg(REG_JUMP_THRESHOLD, {20'h0, thr});
        write_reg(REG_SPIKE_CONFIRM, {24'h0, confirm});
        write_reg(REG_FILTER_ALPHA, {15'h0, gain});
        write_reg(REG_ANGLE_OFFSET, {4'h0, offset});
        write_reg(REG_DIRECTION, {31'h0, rev});
        settings++;
    endtask

    // Random settings, extremes picked often
    task automatic shuffle_settings();
        logic [11:0] thr;
        logic [7:0]  confirm;
        logic [16:0] gain;
        logic [27:0] offset;
        case ($urandom_range(4))
            0:       thr = 12'd0;
            1:       thr = 12'd2048;
            2:       thr = 12'd4095;
            default: thr = 12'($urandom_range(1, 400));
        endcase
        case ($urandom_range(4))
            0:       confirm = 8'd0;
            1:       confirm = 8'd1;
            2:       confirm = 8'd255;
            default: confirm = 8'($urandom_range(2, 6));
        endcase
        case ($urandom_range(4))
            0:       gain = 17'd0;
            1:       gain = ALPHA_ONE;
            2:       gain = 17'h1FFFF;
            default: gain = 17'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(2))
            0:       offset = 28'd0;
            1:       offset = 28'hFFFFFFF;
            default: offset = 28'($urandom);
        endcase
        write_all(thr, confirm, gain, offset, 1'($urandom_range(1)));
    endtask

    // Slow angle walk with spike bursts, real relocations and noise
    task automatic random_phase();
        int          start;
        int          lim;
        int          len;
        logic [11:0] track;
        start = sent_total;
        track = 12'($urandom);
        while (sent_total - start < PHASE_ITEMS) begin
            lim = int'(sb.jump_threshold) / 2 + 1;
            if (lim > 64)
                lim = 64;
            case ($urandom_range(99)) inside
                [0:69]: begin
                    track = track + 12'($urandom_range(0, 2 * lim)) - 12'(lim);
                    send_count(track);
                end
                [70:84]: begin
                    len = $urandom_range(1, 4);
                    repeat (len)
                        send_count(track + 12'h800 + 12'($urandom_range(0, 512)) - 12'd256);
                end
                [85:92]: begin
                    track = 12'($urandom);
                    len   = $urandom_range(1, 6);
                    repeat (len)
                        send_count(track);
                end
                default: send_bytes(8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults: seeding, unused high bits, wrap through zero, half-turn steps
        send_bytes(8'hF0, 8'hFF);
        send_bytes(8'h0F, 8'hFF);
        send_bytes(8'hA0, 8'h01);
        send_bytes(8'h08, 8'h01);
        send_bytes(8'h58, 8'h00);
        send_bytes(8'hFF, 8'hFF);
        send_bytes(8'h00, 8'h00);
        wait_idle();

        // Spike confirmation over three, saturating gain, max offset, reversed
        write_all(12'd10, 8'd3, 17'h1FFFF, 28'hFFFFFFF, 1'b1);
        send_count(12'd5);
        send_count(12'd200);
        send_count(12'd6);
        send_count(12'd300);
        send_count(12'd301);
        send_count(12'd302);
        send_count(12'd303);
        send_count(12'd4000);
        send_count(12'd310);
        wait_idle();

        // Confirm count zero, zero gain, zero threshold
        write_all(12'd0, 8'd0, 17'd0, 28'd0, 1'b0);
        send_count(12'd100);
        send_count(12'd2000);
        send_count(12'd2000);
        send_count(12'd7);
        wait_idle();

        // Random phases; one without idling, some with a long result stall
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            shuffle_settings();
            src_idle_pct = (ph == 2) ? 0 : 24;
            snk_idle_pct = (ph == 2) ? 0 : 24;
            if (ph % 3 == 1)
                hold_req = 1'b1;
            random_phase();
            wait_idle();
        end

        $display("Covered %0d requests (%0d held back as spikes), %0d results checked,",
                 sb.requests, sb.rejected, sb.checked);
        $display("over %0d register settings with idles, long stalls and full-rate stretches.",
                 settings);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
